### hdl/slbm_pkg.sv
// Package for the status LED brightness mixer: item types, register indexes,
// register reset values and the arithmetic constants of the mixer.
// No dependencies; used by status_led_brightness_mixer_core.
package slbm_pkg;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [31:0] read_count;
        logic [7:0]  event_head;
        logic        transport_play;
        logic [31:0] clock_ticks;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pwm_duty;
        logic       link_active;
    } t_out_item;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINK_TIMEOUT = 3'd0,
        CFG_LINKED_GLOW  = 3'd1,
        CFG_FLASH_DECAY  = 3'd2,
        CFG_BEAT_PEAK    = 3'd3,
        CFG_BEAT_DECAY   = 3'd4
    } t_cfg_index;

    localparam logic [15:0] LINK_TIMEOUT_RST = 16'd500;
    localparam logic [7:0]  LINKED_GLOW_RST  = 8'd60;
    localparam logic [7:0]  FLASH_DECAY_RST  = 8'd28;
    localparam logic [7:0]  BEAT_PEAK_RST    = 8'd150;
    localparam logic [7:0]  BEAT_DECAY_RST   = 8'd12;

    localparam logic [7:0]  FLASH_PEAK      = 8'd255;
    localparam logic [11:0] BREATHE_PERIOD  = 12'd2400;
    localparam logic [11:0] BREATHE_HALF    = 12'd1200;
    localparam logic [7:0]  BREATHE_MIN     = 8'd6;

    // floor(x / 75) = (x * TIME_RECIP) >> 34 for any 27-bit x.
    localparam logic [27:0] TIME_RECIP = 28'd229064923;
    localparam int          TIME_SHIFT = 34;
    // floor(x / 3) = (x * TICK_RECIP) >> 31 for any 29-bit x.
    localparam logic [29:0] TICK_RECIP = 30'd715827883;
    localparam int          TICK_SHIFT = 31;
    // floor(t / 5) = (t * FIFTH_RECIP) >> 10 for t below 1024.
    localparam logic [7:0]  FIFTH_RECIP = 8'd205;
    localparam int          FIFTH_SHIFT = 10;

endpackage

### hdl/status_led_brightness_mixer_core.sv
// Status LED brightness mixer core: five-stage pipeline from update snapshot
// to PWM duty and link flag, with the configuration registers.
// Depends on slbm_pkg.
//
// Usage: the input channel (i_valid, o_stall, i_item) takes one update
// snapshot per item; the output channel (o_valid, i_stall, o_item) gives
// one duty and link flag per item, in order. An item is taken at a clock
// edge with valid high and stall low.
// An item passes through r_s1, r_s2, r_s3, r_bright and r_out to o_valid,
// and one item is taken every cycle while the output is not stalled. The
// stage for the seen counters and pulse levels updates them all together.
// The earlier stages split the time and tick counters by 2400 and 24.
// When the receiver stalls, the result holds in the output register and
// the stages behind it keep filling; o_stall rises only once all stages
// hold an item.
// Configuration writes (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data)
// are always ready; the user must make them while no item is in flight, as the block does not enforce it.
// A synchronous reset empties the pipeline, zeroes the tracking state and
// loads the register defaults.
module status_led_brightness_mixer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  slbm_pkg::t_in_item                i_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output slbm_pkg::t_out_item               o_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [slbm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [slbm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef struct packed {
        slbm_pkg::t_in_item item;
        logic [20:0]        q_time;
        logic [27:0]        q_tick;
    } t_s2;

    typedef struct packed {
        slbm_pkg::t_in_item item;
        logic [11:0]        phase;
        logic               beat_mark;
    } t_s3;

    logic [15:0] r_link_timeout;
    logic [7:0]  r_linked_glow;
    logic [7:0]  r_flash_decay;
    logic [7:0]  r_beat_peak;
    logic [7:0]  r_beat_decay;

    logic [31:0] r_seen_reads;
    logic [31:0] r_last_read_time;
    logic [7:0]  r_seen_head;
    logic [31:0] r_seen_ticks;
    logic [7:0]  r_flash_level;
    logic [7:0]  r_beat_level;

    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    slbm_pkg::t_in_item  r_s1;
    t_s2                 r_s2;
    t_s3                 r_s3;
    logic [7:0]          r_bright;
    logic                r_link;
    slbm_pkg::t_out_item r_out;

    logic ready_out, ready4, ready3, ready2, ready1, fire3;

    logic [54:0] time_prod;
    logic [58:0] tick_prod;
    t_s2         n_s2;

    logic [32:0] q_time_scaled;
    logic [31:0] phase_full;
    logic [29:0] q_tick_x3;
    t_s3         n_s3;

    logic [31:0] n_last_read_time;
    logic [31:0] elapsed;
    logic        n_link;
    logic [7:0]  flash_cur;
    logic        tick_new;
    logic [7:0]  beat_cur;
    logic [11:0] tri_val;
    logic [15:0] fifth_prod;
    logic [7:0]  breathe;
    logic [7:0]  base;
    logic [7:0]  n_bright;
    logic [7:0]  n_flash_level;
    logic [7:0]  n_beat_level;

    logic [15:0] square;
    logic [16:0] duty_sum;
    slbm_pkg::t_out_item n_out;

    assign ready_out   = !r_out_valid || !i_stall;
    assign ready4      = !r_v4 || ready_out;
    assign ready3      = !r_v3 || ready4;
    assign ready2      = !r_v2 || ready3;
    assign ready1      = !r_v1 || ready2;
    assign fire3       = r_v3 && ready4;
    assign o_stall     = !ready1;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        time_prod   = {28'b0, r_s1.time_ms[31:5]} * {27'b0, slbm_pkg::TIME_RECIP};
        tick_prod   = {30'b0, r_s1.clock_ticks[31:3]} * {29'b0, slbm_pkg::TICK_RECIP};
        n_s2.item   = r_s1;
        n_s2.q_time = time_prod[slbm_pkg::TIME_SHIFT +: 21];
        n_s2.q_tick = tick_prod[slbm_pkg::TICK_SHIFT +: 28];
    end

    always_comb begin
        q_time_scaled  = {12'b0, r_s2.q_time} * {21'b0, slbm_pkg::BREATHE_PERIOD};
        phase_full     = r_s2.item.time_ms - q_time_scaled[31:0];
        q_tick_x3      = {2'b0, r_s2.q_tick} + {1'b0, r_s2.q_tick, 1'b0};
        n_s3.item      = r_s2.item;
        n_s3.phase     = phase_full[11:0];
        n_s3.beat_mark = (r_s2.item.clock_ticks[2:0] == 3'b0)
                         && ({1'b0, r_s2.item.clock_ticks[31:3]} == q_tick_x3);
    end

    always_comb begin
        n_last_read_time = (r_s3.item.read_count != r_seen_reads)
                           ? r_s3.item.time_ms : r_last_read_time;
        elapsed   = r_s3.item.time_ms - n_last_read_time;
        n_link    = elapsed < {16'b0, r_link_timeout};
        flash_cur = (r_s3.item.event_head != r_seen_head)
                    ? slbm_pkg::FLASH_PEAK : r_flash_level;
        tick_new  = r_s3.item.transport_play && (r_s3.item.clock_ticks != r_seen_ticks);
        beat_cur  = (tick_new && r_s3.beat_mark) ? r_beat_peak : r_beat_level;
        tri_val   = (r_s3.phase < slbm_pkg::BREATHE_HALF)
                    ? r_s3.phase : slbm_pkg::BREATHE_PERIOD - r_s3.phase;
        fifth_prod = {8'b0, tri_val[10:3]} * {8'b0, slbm_pkg::FIFTH_RECIP};
        breathe   = slbm_pkg::BREATHE_MIN
                    + {2'b0, fifth_prod[slbm_pkg::FIFTH_SHIFT +: 6]};
        base      = n_link ? r_linked_glow : breathe;
        n_bright  = base;
        if (flash_cur > n_bright) begin
            n_bright = flash_cur;
        end
        if (beat_cur > n_bright) begin
            n_bright = beat_cur;
        end
        n_flash_level = (flash_cur > r_flash_decay) ? flash_cur - r_flash_decay : 8'd0;
        n_beat_level  = (beat_cur > r_beat_decay) ? beat_cur - r_beat_decay : 8'd0;
    end

    always_comb begin
        square            = {8'b0, r_bright} * {8'b0, r_bright};
        duty_sum          = {1'b0, square} + {9'b0, square[15:8]} + 17'd1;
        n_out.pwm_duty    = duty_sum[15:8];
        n_out.link_active = r_link;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_timeout <= slbm_pkg::LINK_TIMEOUT_RST;
            r_linked_glow  <= slbm_pkg::LINKED_GLOW_RST;
            r_flash_decay  <= slbm_pkg::FLASH_DECAY_RST;
            r_beat_peak    <= slbm_pkg::BEAT_PEAK_RST;
            r_beat_decay   <= slbm_pkg::BEAT_DECAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (slbm_pkg::t_cfg_index'(i_cfg_index))
                slbm_pkg::CFG_LINK_TIMEOUT: r_link_timeout <= i_cfg_data;
                slbm_pkg::CFG_LINKED_GLOW:  r_linked_glow  <= i_cfg_data[7:0];
                slbm_pkg::CFG_FLASH_DECAY:  r_flash_decay  <= i_cfg_data[7:0];
                slbm_pkg::CFG_BEAT_PEAK:    r_beat_peak    <= i_cfg_data[7:0];
                slbm_pkg::CFG_BEAT_DECAY:   r_beat_decay   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_reads     <= '0;
            r_last_read_time <= '0;
            r_seen_head      <= '0;
            r_seen_ticks     <= '0;
            r_flash_level    <= '0;
            r_beat_level     <= '0;
        end else if (fire3) begin
            r_seen_reads     <= r_s3.item.read_count;
            r_last_read_time <= n_last_read_time;
            r_seen_head      <= r_s3.item.event_head;
            if (tick_new) begin
                r_seen_ticks <= r_s3.item.clock_ticks;
            end
            r_flash_level    <= n_flash_level;
            r_beat_level     <= n_beat_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
            if (ready4) begin
                r_v4 <= r_v3;
            end
            if (ready_out) begin
                r_out_valid <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_s1 <= i_item;
        end
        if (ready2) begin
            r_s2 <= n_s2;
        end
        if (ready3) begin
            r_s3 <= n_s3;
        end
        if (ready4) begin
            r_bright <= n_bright;
            r_link   <= n_link;
        end
        if (ready_out) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_link_needs_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.link_active |-> r_link_timeout != 16'd0)
        else $error("link flagged with zero timeout");

    a_out_from_stage4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_v4))
        else $error("result appeared without a stage-four item");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire3 |=> $stable(r_flash_level) && $stable(r_beat_level)
                   && $stable(r_seen_reads) && $stable(r_seen_head))
        else $error("tracking state changed without an item");

    a_no_stall_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("input stalled with an empty input stage");
`endif

endmodule
